// ===== src/ssba_pkg.sv =====
`default_nettype none

package ssba_pkg;

  localparam int unsigned MaxSlotsDefault       = 1024;
  localparam int unsigned SectorsPerSlotDefault = 2;

  localparam int unsigned SlotCountW  = 11;
  localparam int unsigned SlotW       = 10;
  localparam int unsigned SectorW     = 11;
  localparam int unsigned MapWordW    = 64;
  // Largest slot count that the configuration register can express.
  localparam int unsigned MaxCountValue = (1 << SlotCountW) - 1;

  localparam logic [SlotCountW-1:0] SlotCountReset = 11'd1024;

  localparam int unsigned QueueDepth = 2;

  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_NOT_USED = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_RANGE = 2'd2
  } op_kind_e;

  typedef struct packed {
    logic             mode;
    logic [SlotW-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [SlotW-1:0]   granted_slot;
    logic [SectorW-1:0] sector_address;
    status_e            status;
    logic               last;
  } rsp_t;

  typedef struct packed {
    op_kind_e         kind;
    logic [SlotW-1:0] slot;
  } op_t;

endpackage

`default_nettype wire

// ===== src/ssba_front.sv =====
`default_nettype none

module ssba_front #(
  parameter int unsigned MAX_SLOTS = ssba_pkg::MaxSlotsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ssba_pkg::SlotCountW-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  input  ssba_pkg::req_t                       in_i,
  output logic                                 in_stall_o,
  output logic                                 push_o,
  output ssba_pkg::op_t                        op_o,
  input  logic                                 full_i,
  output logic [ssba_pkg::SlotCountW-1:0]      limit_o
);

  localparam int unsigned EffSlots =
    (MAX_SLOTS < ssba_pkg::MaxCountValue) ? MAX_SLOTS : ssba_pkg::MaxCountValue;
  localparam logic [ssba_pkg::SlotCountW-1:0] MaxLimit = ssba_pkg::SlotCountW'(EffSlots);

  logic [ssba_pkg::SlotCountW-1:0] slot_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= ssba_pkg::SlotCountReset;
    end else if (cfg_we_i) begin
      slot_count_q <= cfg_wdata_i;
    end
  end

  assign limit_o    = (slot_count_q > MaxLimit) ? MaxLimit : slot_count_q;
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  // Range is settled here so the back end only touches slots it may own.
  always_comb begin
    op_o.slot = in_i.slot_index;
    if (in_i.mode == ssba_pkg::ModeAlloc) begin
      op_o.kind = ssba_pkg::OP_ALLOC;
    end else if (ssba_pkg::SlotCountW'(in_i.slot_index) >= limit_o) begin
      op_o.kind = ssba_pkg::OP_RANGE;
    end else begin
      op_o.kind = ssba_pkg::OP_FREE;
    end
  end

endmodule

`default_nettype wire

// ===== src/ssba_fifo.sv =====
`default_nettype none

module ssba_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ssba_pkg::op_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output ssba_pkg::op_t data_o,
  output logic          empty_o
);

  localparam int unsigned Depth = ssba_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  ssba_pkg::op_t   entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ssba_back.sv =====
`default_nettype none

module ssba_back #(
  parameter int unsigned MAX_SLOTS        = ssba_pkg::MaxSlotsDefault,
  parameter int unsigned SECTORS_PER_SLOT = ssba_pkg::SectorsPerSlotDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [ssba_pkg::SlotCountW-1:0] limit_i,
  input  logic                            empty_i,
  input  ssba_pkg::op_t                   op_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output ssba_pkg::rsp_t                  out_o
);

  localparam int unsigned EffSlots =
    (MAX_SLOTS < ssba_pkg::MaxCountValue) ? MAX_SLOTS : ssba_pkg::MaxCountValue;
  localparam int unsigned WordW    = ssba_pkg::MapWordW;
  localparam int unsigned Words    = (EffSlots + WordW - 1) / WordW;
  localparam int unsigned WordIdxW = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned SecIdxW  = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;
  localparam int unsigned CW       = ssba_pkg::SlotCountW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_EMIT,
    S_RESP
  } state_e;

  function automatic logic [2:0] first_set8(input logic [7:0] v);
    logic [2:0] idx;
    idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

  // Slot bitmap, one 64-bit word per row.
  logic [WordW-1:0]    map_mem [Words];
  logic [WordW-1:0]    rd_data_q;
  logic                rd_valid_q;
  logic [Words-1:0]    row_valid_q;
  logic [Words-1:0]    full_q;

  state_e              state_q;
  ssba_pkg::op_kind_e  kind_q;
  ssba_pkg::status_e   status_q;
  logic [CW-1:0]       slot_q;
  logic [WordIdxW-1:0] word_q;
  logic [SecIdxW-1:0]  sec_q;
  logic [WordW-1:0]    raw_q;
  logic [WordW-1:0]    masked_q;
  logic [7:0]          byte_free_q;
  logic                out_valid_q;
  ssba_pkg::rsp_t      out_q;

  logic [5:0]          limit_words;
  logic [Words-1:0]    cand;
  logic                have_cand;
  logic [WordIdxW-1:0] first_cand;
  logic                mem_re;
  logic [WordIdxW-1:0] rd_addr;
  logic [WordW-1:0]    cur_word;
  logic                is_used;
  logic [WordW-1:0]    lim_mask;
  logic [WordW-1:0]    masked;
  logic [7:0]          byte_free_d;
  logic [2:0]          byte_idx;
  logic [7:0]          sel_byte;
  logic [2:0]          bit_idx;
  logic [CW-1:0]       alloc_slot;
  logic                mem_we;
  logic [WordW-1:0]    mem_wdata;
  logic [15:0]         sec_full;
  logic                sec_last;
  logic                out_free;

  // A word can hold the next allocation if it is not full and starts below the limit.
  always_comb begin
    limit_words = 6'((12'(limit_i) + 12'd63) >> 6);
    first_cand  = '0;
    for (int w = 0; w < Words; w++) begin
      cand[w] = !full_q[w] && (6'(w) < limit_words);
    end
    for (int w = Words - 1; w >= 0; w--) begin
      if (cand[w]) begin
        first_cand = WordIdxW'(w);
      end
    end
    have_cand = |cand;
  end

  assign pop_o   = (state_q == S_IDLE) && !empty_i;
  assign mem_re  = pop_o && (op_i.kind != ssba_pkg::OP_RANGE);
  assign rd_addr = (op_i.kind == ssba_pkg::OP_FREE) ? WordIdxW'(op_i.slot[9:6]) : first_cand;

  // Rows never written read as all free.
  assign cur_word = rd_valid_q ? rd_data_q : '0;
  assign is_used  = cur_word[slot_q[5:0]];

  // Slots at or above the limit in the limit's own word count as taken for the scan.
  assign lim_mask = (5'(word_q) == limit_i[10:6]) ?
                    ~((64'd1 << limit_i[5:0]) - 64'd1) : '0;
  assign masked   = cur_word | lim_mask;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      byte_free_d[b] = ~&masked[b*8 +: 8];
    end
  end

  assign byte_idx   = first_set8(byte_free_q);
  assign sel_byte   = masked_q[byte_idx*8 +: 8];
  assign bit_idx    = first_set8(~sel_byte);
  assign alloc_slot = CW'({word_q, byte_idx, bit_idx});

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = raw_q | (64'd1 << {byte_idx, bit_idx});
    if (state_q == S_READ && kind_q == ssba_pkg::OP_FREE && is_used) begin
      mem_we    = 1'b1;
      mem_wdata = cur_word & ~(64'd1 << slot_q[5:0]);
    end else if (state_q == S_SCAN && (|byte_free_q)) begin
      mem_we = 1'b1;
    end
  end

  assign sec_full = 16'(slot_q) * 16'(SECTORS_PER_SLOT) + 16'(sec_q);
  assign sec_last = (sec_q == SecIdxW'(SECTORS_PER_SLOT - 1));
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[word_q] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= map_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      row_valid_q <= '0;
      full_q      <= '0;
      sec_q       <= '0;
    end else begin
      // The output register loads a new word whenever it is free to.
      if (out_free) begin
        out_valid_q <= (state_q == S_EMIT) || (state_q == S_RESP);
      end
      if (mem_we) begin
        row_valid_q[word_q] <= 1'b1;
        full_q[word_q]      <= &mem_wdata;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            kind_q     <= op_i.kind;
            slot_q     <= (op_i.kind == ssba_pkg::OP_ALLOC) ? '0 : CW'(op_i.slot);
            word_q     <= rd_addr;
            sec_q      <= '0;
            rd_valid_q <= row_valid_q[rd_addr];
            unique case (op_i.kind)
              ssba_pkg::OP_ALLOC: begin
                if (have_cand) begin
                  state_q <= S_READ;
                end else begin
                  status_q <= ssba_pkg::ST_NO_FREE;
                  state_q  <= S_RESP;
                end
              end
              ssba_pkg::OP_FREE: begin
                state_q <= S_READ;
              end
              ssba_pkg::OP_RANGE: begin
                status_q <= ssba_pkg::ST_RANGE;
                state_q  <= S_RESP;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_READ: begin
          if (kind_q == ssba_pkg::OP_FREE) begin
            if (is_used) begin
              state_q <= S_EMIT;
            end else begin
              status_q <= ssba_pkg::ST_NOT_USED;
              state_q  <= S_RESP;
            end
          end else begin
            raw_q       <= cur_word;
            masked_q    <= masked;
            byte_free_q <= byte_free_d;
            state_q     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (|byte_free_q) begin
            slot_q  <= alloc_slot;
            state_q <= S_EMIT;
          end else begin
            status_q <= ssba_pkg::ST_NO_FREE;
            slot_q   <= '0;
            state_q  <= S_RESP;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_q.granted_slot   <= slot_q[ssba_pkg::SlotW-1:0];
            out_q.sector_address <= sec_full[ssba_pkg::SectorW-1:0];
            out_q.status         <= ssba_pkg::ST_OK;
            out_q.last           <= sec_last;
            if (sec_last) begin
              state_q <= S_IDLE;
            end else begin
              sec_q <= sec_q + 1'b1;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_q.granted_slot   <= slot_q[ssba_pkg::SlotW-1:0];
            out_q.sector_address <= '0;
            out_q.status         <= status_q;
            out_q.last           <= 1'b1;
            state_q              <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ===== src/swap_slot_bitmap_allocator_unit.sv =====
// Swap slot allocator over a bitmap of in-use slots.
// Request channel (in_valid_i / in_stall_o / in_i): mode 0 allocates the lowest
// free slot below the usable count, mode 1 frees in_i.slot_index.
// Result channel (out_valid_o / out_stall_i / out_o): a granted or freed slot
// gives one word per device sector, sector_address = slot * SECTORS_PER_SLOT + n,
// with last set on the final one. An error gives a single word with its status.
// The slot count register is written through cfg_we_i / cfg_wdata_i; values
// above MAX_SLOTS saturate.
// A two-entry request queue sits between the front end and the bitmap engine.
// The engine holds one request at a time: an allocate picks a non-full word,
// does one bitmap memory read and one two-level scan, then gives one word per
// sector; a free does the read and then gives its words. With an empty queue an
// allocate passes through READ, SCAN and EMIT into the output register, a free
// through READ and EMIT, and an out-of-range free through RESP.
// Reset clears the map to all free (per-row valid bits, no clearing pass), sets
// the slot count to 1024 and empties the queue and the output register.
// A stalled receiver holds the result word; the engine waits and the queue
// keeps taking requests until it is full.
`default_nettype none

module swap_slot_bitmap_allocator_unit #(
  parameter int unsigned MAX_SLOTS        = ssba_pkg::MaxSlotsDefault,
  parameter int unsigned SECTORS_PER_SLOT = ssba_pkg::SectorsPerSlotDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ssba_pkg::SlotCountW-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  ssba_pkg::req_t                  in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output ssba_pkg::rsp_t                  out_o
);

  logic                            push;
  logic                            full;
  logic                            pop;
  logic                            empty;
  ssba_pkg::op_t                   op_in;
  ssba_pkg::op_t                   op_out;
  logic [ssba_pkg::SlotCountW-1:0] limit;

  ssba_front #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_i        (in_i),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .op_o        (op_in),
    .full_i      (full),
    .limit_o     (limit)
  );

  ssba_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (op_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (op_out),
    .empty_o (empty)
  );

  ssba_back #(
    .MAX_SLOTS        (MAX_SLOTS),
    .SECTORS_PER_SLOT (SECTORS_PER_SLOT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (limit),
    .empty_i     (empty),
    .op_i        (op_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== src/ssba_checker.sv =====
`default_nettype none

module ssba_checker #(
  parameter int unsigned SECTORS_PER_SLOT = ssba_pkg::SectorsPerSlotDefault
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input ssba_pkg::rsp_t out_o
);

  // A word held back by the receiver stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("result word changed while stalled");

  // Every error is reported as a request's only word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != ssba_pkg::ST_OK |-> out_o.last)
    else $error("error result without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != ssba_pkg::ST_OK |-> out_o.sector_address == '0)
    else $error("error result carries a sector address");

  // The closing sector of a slot is the slot's last device sector.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == ssba_pkg::ST_OK && out_o.last |->
      out_o.sector_address == 11'(16'(out_o.granted_slot) * 16'(SECTORS_PER_SLOT)
                                  + 16'(SECTORS_PER_SLOT - 1)))
    else $error("last sector address does not match granted slot");

endmodule

bind swap_slot_bitmap_allocator_unit ssba_checker #(
  .SECTORS_PER_SLOT (SECTORS_PER_SLOT)
) u_ssba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;

  localparam int unsigned CycleLimit = 600000;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            cfg_we_i    = 1'b0;
  logic [ssba_pkg::SlotCountW-1:0] cfg_wdata_i = '0;
  logic                            in_valid_i  = 1'b0;
  ssba_pkg::req_t                  in_i        = '0;
  logic                            out_stall_i = 1'b0;
  logic                            in_stall_o;
  logic                            out_valid_o;
  ssba_pkg::rsp_t                  out_o;

  // Mirror of the block: one in-use flag per slot and the slot count register.
  bit                              slot_in_use [ssba_pkg::MaxSlotsDefault];
  logic [ssba_pkg::SlotCountW-1:0] slot_count_q = ssba_pkg::SlotCountReset;
  ssba_pkg::rsp_t                  pending_words [$];

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  bit          steady      = 1'b0;

  swap_slot_bitmap_allocator_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned usable_slots();
    if (slot_count_q > ssba_pkg::SlotCountW'(ssba_pkg::MaxSlotsDefault))
      return ssba_pkg::MaxSlotsDefault;
    return 32'(slot_count_q);
  endfunction

  function automatic void push_sector_words(input int unsigned slot);
    ssba_pkg::rsp_t w;
    for (int unsigned n = 0; n < ssba_pkg::SectorsPerSlotDefault; n++) begin
      w.granted_slot   = ssba_pkg::SlotW'(slot);
      w.sector_address = ssba_pkg::SectorW'(slot * ssba_pkg::SectorsPerSlotDefault + n);
      w.status         = ssba_pkg::ST_OK;
      w.last           = (n == ssba_pkg::SectorsPerSlotDefault - 1);
      pending_words.push_back(w);
    end
  endfunction

  function automatic void push_error_word(input int unsigned slot,
                                          input ssba_pkg::status_e code);
    ssba_pkg::rsp_t w;
    w.granted_slot   = ssba_pkg::SlotW'(slot);
    w.sector_address = '0;
    w.status         = code;
    w.last           = 1'b1;
    pending_words.push_back(w);
  endfunction

  // Applies one accepted request to the mirrored map and queues its words.
  function automatic void allocate_or_free(input ssba_pkg::req_t r);
    int unsigned usable;
    usable = usable_slots();
    if (r.mode == ssba_pkg::ModeAlloc) begin
      for (int unsigned s = 0; s < usable; s++) begin
        if (!slot_in_use[s]) begin
          slot_in_use[s] = 1'b1;
          push_sector_words(s);
          return;
        end
      end
      push_error_word(0, ssba_pkg::ST_NO_FREE);
    end else if (32'(r.slot_index) >= usable) begin
      push_error_word(32'(r.slot_index), ssba_pkg::ST_RANGE);
    end else if (!slot_in_use[r.slot_index]) begin
      push_error_word(32'(r.slot_index), ssba_pkg::ST_NOT_USED);
    end else begin
      slot_in_use[r.slot_index] = 1'b0;
      push_sector_words(32'(r.slot_index));
    end
  endfunction

  function automatic int pick_used_slot(input int unsigned usable);
    int unsigned start;
    int unsigned s;
    if (usable == 0) return -1;
    start = $urandom_range(0, usable - 1);
    for (int unsigned k = 0; k < usable; k++) begin
      s = (start + k) % usable;
      if (slot_in_use[s]) return int'(s);
    end
    return -1;
  endfunction

  // Called in the time step of a rising edge. Valid stays high after the
  // handshake when no gap follows, so back-to-back words are possible.
  task automatic send_request(input logic mode, input int unsigned idx);
    ssba_pkg::req_t r;
    int unsigned    gap;
    r.mode       = mode;
    r.slot_index = ssba_pkg::SlotW'(idx);
    in_valid_i <= 1'b1;
    in_i       <= r;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    allocate_or_free(r);
    gap = steady ? 0 : idle_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_slot_count(input logic [ssba_pkg::SlotCountW-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    slot_count_q  = value;
  endtask

  task automatic test_after_reset();
    send_request(ssba_pkg::ModeAlloc, 1023);
    send_request(ssba_pkg::ModeAlloc, 0);
    send_request(ssba_pkg::ModeFree, 0);
    send_request(ssba_pkg::ModeFree, 0);
    send_request(ssba_pkg::ModeFree, 1023);
    send_request(ssba_pkg::ModeAlloc, 512);
  endtask

  task automatic test_zero_count();
    set_slot_count('0);
    send_request(ssba_pkg::ModeAlloc, 0);
    send_request(ssba_pkg::ModeFree, 0);
    send_request(ssba_pkg::ModeFree, 1023);
  endtask

  // Slots left in use above a lowered count are out of range for a free.
  task automatic test_shrunk_count();
    set_slot_count(11'd3);
    send_request(ssba_pkg::ModeAlloc, 0);
    send_request(ssba_pkg::ModeAlloc, 0);
    set_slot_count(11'd1);
    send_request(ssba_pkg::ModeFree, 2);
    send_request(ssba_pkg::ModeAlloc, 0);
    send_request(ssba_pkg::ModeFree, 1);
    send_request(ssba_pkg::ModeFree, 0);
    send_request(ssba_pkg::ModeAlloc, 0);
  endtask

  task automatic test_random_traffic(input logic [ssba_pkg::SlotCountW-1:0] count,
                                     input int unsigned n_items, input bit no_idle);
    int unsigned roll;
    int          slot;
    logic        mode;
    int unsigned idx;
    set_slot_count(count);
    steady = no_idle;
    repeat (n_items) begin
      roll = $urandom_range(0, 99);
      mode = ssba_pkg::ModeAlloc;
      idx  = $urandom_range(0, 1023);
      if (roll >= 45 && roll < 80) begin
        slot = pick_used_slot(usable_slots());
        if (slot >= 0) begin
          mode = ssba_pkg::ModeFree;
          idx  = unsigned'(slot);
        end
      end else if (roll >= 80 && roll < 90) begin
        mode = ssba_pkg::ModeFree;
      end else if (roll >= 90 && usable_slots() != 0) begin
        mode = ssba_pkg::ModeFree;
        idx  = $urandom_range(0, usable_slots() - 1);
      end
      send_request(mode, idx);
    end
    steady = 1'b0;
  endtask

  // Fills every slot below a count that ends inside a map word, so the scan
  // runs into the limit, then checks that an oversized count saturates.
  task automatic test_fill_and_saturate();
    int unsigned free_left;
    set_slot_count(11'd70);
    free_left = 0;
    for (int unsigned s = 0; s < 70; s++) begin
      if (!slot_in_use[s]) free_left++;
    end
    repeat (free_left) send_request(ssba_pkg::ModeAlloc, $urandom_range(0, 1023));
    send_request(ssba_pkg::ModeAlloc, 0);
    send_request(ssba_pkg::ModeFree, 69);
    send_request(ssba_pkg::ModeFree, 69);
    send_request(ssba_pkg::ModeAlloc, 0);
    send_request(ssba_pkg::ModeFree, 70);
    set_slot_count(11'd2047);
    send_request(ssba_pkg::ModeFree, 1023);
    send_request(ssba_pkg::ModeAlloc, 0);
    send_request(ssba_pkg::ModeFree, 0);
    send_request(ssba_pkg::ModeAlloc, 1023);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_after_reset();
    test_zero_count();
    test_shrunk_count();
    test_random_traffic(11'd64, 100, 1'b0);
    test_random_traffic(11'd8, 80, 1'b0);
    test_random_traffic(11'd1024, 130, 1'b0);
    test_random_traffic(11'd200, 90, 1'b1);
    test_random_traffic(11'd3, 70, 1'b0);
    test_fill_and_saturate();
    drain_results();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver stalls come in bursts; no new burst starts in a steady phase.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      stall_left = idle_gap() + 1;
    end
    out_stall_i <= (stall_left != 0);
  end

  task automatic report_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    ssba_pkg::rsp_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got slot %0d sector %0d status %0d",
                 $time, out_o.granted_slot, out_o.sector_address, out_o.status);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        if (out_o.granted_slot !== want.granted_slot)
          report_field("granted_slot", 16'(want.granted_slot), 16'(out_o.granted_slot));
        if (out_o.sector_address !== want.sector_address)
          report_field("sector_address", 16'(want.sector_address),
                       16'(out_o.sector_address));
        if (out_o.status !== want.status)
          report_field("status", 16'(want.status), 16'(out_o.status));
        if (out_o.last !== want.last)
          report_field("last", 16'(want.last), 16'(out_o.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

`default_nettype wire
